>>> rtl/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types, codes and sizing constants of the partitioned stack memory.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int NUM_STACKS    = 8;
    localparam int MEM_DEPTH     = 128;
    localparam int MAX_WORDS     = 16;

    localparam int SIZE_RAW      = MEM_DEPTH / NUM_STACKS;
    localparam int SIZE_CAP      = (SIZE_RAW > MAX_WORDS) ? MAX_WORDS : SIZE_RAW;
    localparam int SIZE_LIMIT    = (SIZE_CAP < 1) ? 1 : SIZE_CAP;

    localparam int ADDR_W        = $clog2(MEM_DEPTH);
    localparam int STK_W         = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int POS_W         = (SIZE_LIMIT > 1) ? $clog2(SIZE_LIMIT) : 1;
    localparam int SIZE_W        = 5;
    localparam int NUM_W         = 4;
    localparam int DATA_W        = 32;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;
    localparam int IN_TDATA_W    = 40;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_ACCESS,
        S_DATA
    } state_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (r < SIZE_W'(1))
            r = SIZE_W'(1);
        if (r > SIZE_W'(SIZE_LIMIT))
            r = SIZE_W'(SIZE_LIMIT);
        return r;
    endfunction

endpackage

>>> rtl/msp_store.sv
// ----------------------------------------------------------------------------
// msp_store
// Shared element memory: one address port that writes and gives a registered read.
// ----------------------------------------------------------------------------
module msp_store
    import msp_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [MEM_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/multi_stack_partitioned_memory_unit.sv
// ----------------------------------------------------------------------------
// multi_stack_partitioned_memory_unit
// Several stacks kept in one shared memory, each in a fixed slice.
// ----------------------------------------------------------------------------
// One transaction at a time is processed. Each accepted transaction is checked
// in S_CHECK; a push then writes in S_ACCESS, a pop reads via S_ACCESS and
// S_DATA, a read-out passes S_ACCESS and S_DATA once per stored element, and
// errors are answered from S_CHECK. All stacks share the single memory port
// and the slice-address adder. Writing stack_size empties every stack.
module multi_stack_partitioned_memory_unit
    import msp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // stack_number[3:0], push_value[35:4]
    input  logic [OP_W-1:0]       s_axis_tuser,   // operation[1:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [DATA_W-1:0]     m_axis_tdata,   // data_out[31:0]
    output logic [STATUS_W-1:0]   m_axis_tuser,   // status[1:0]
    output logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [SIZE_W-1:0]     cfg_data
);

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [SIZE_W-1:0]   count_reg, count_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [SIZE_W-1:0]   fill_reg [NUM_STACKS];
    logic [SIZE_W-1:0]   fill_next [NUM_STACKS];
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_data_reg, out_data_next;
    status_t             out_status_reg, out_status_next;
    logic                out_last_reg, out_last_next;

    logic                out_free;
    logic [STK_W-1:0]    stk;
    logic [SIZE_W-1:0]   fill;
    logic                num_bad;
    logic [ADDR_W-1:0]   addr;
    logic                mem_we;
    logic [DATA_W-1:0]   mem_rdata;
    logic                read_last;

    msp_store u_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  (addr),
        .wdata (val_reg),
        .rdata (mem_rdata)
    );

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign stk       = STK_W'(num_reg - NUM_W'(1));
    assign fill      = fill_reg[stk];
    assign num_bad   = (num_reg == '0) || ({1'b0, num_reg} > (NUM_W+1)'(NUM_STACKS));
    assign addr      = base_reg + ADDR_W'(pos_reg);
    assign read_last = ({1'b0, pos_reg} + (POS_W+1)'(1)) == (POS_W+1)'(count_reg);

    assign s_axis_tready = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready     = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        num_next        = num_reg;
        val_next        = val_reg;
        base_next       = base_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        size_next       = size_reg;
        fill_next       = fill_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    size_next = clamp_size(cfg_data);
                    fill_next = '{default: '0};
                end
                else if (s_axis_tvalid)
                begin
                    op_next    = op_t'(s_axis_tuser);
                    num_next   = s_axis_tdata[NUM_W-1:0];
                    val_next   = s_axis_tdata[NUM_W+DATA_W-1:NUM_W];
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                base_next  = ADDR_W'(stk) * ADDR_W'(size_reg);
                count_next = fill;
                if (op_reg == OP_NONE)
                begin
                    state_next = S_IDLE;
                end
                else if (num_bad || (op_reg == OP_PUSH && fill >= size_reg)
                         || (op_reg != OP_PUSH && fill == '0))
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_data_next   = '0;
                        out_last_next   = 1'b1;
                        out_status_next = num_bad ? ST_INVALID :
                                          (op_reg == OP_PUSH) ? ST_FULL : ST_EMPTY;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    case (op_reg)
                        OP_PUSH: pos_next = fill[POS_W-1:0];
                        OP_POP:  pos_next = POS_W'(fill - SIZE_W'(1));
                        default: pos_next = '0;
                    endcase
                    state_next = S_ACCESS;
                end
            end

            S_ACCESS:
            begin
                if (op_reg == OP_PUSH)
                begin
                    mem_we = 1'b1;
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_data_next   = '0;
                        out_status_next = ST_OK;
                        out_last_next   = 1'b1;
                        fill_next[stk]  = fill + SIZE_W'(1);
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_DATA;
                end
            end

            S_DATA:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = mem_rdata;
                    out_status_next = ST_OK;
                    if (op_reg == OP_POP)
                    begin
                        out_last_next  = 1'b1;
                        fill_next[stk] = fill - SIZE_W'(1);
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        out_last_next = read_last;
                        if (read_last)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            pos_next   = pos_reg + POS_W'(1);
                            state_next = S_ACCESS;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= SIZE_W'(SIZE_LIMIT);
            out_valid_reg <= 1'b0;
            fill_reg      <= '{default: '0};
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            out_valid_reg <= out_valid_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        num_reg        <= num_next;
        val_reg        <= val_next;
        base_reg       <= base_next;
        pos_reg        <= pos_next;
        count_reg      <= count_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

endmodule

>>> rtl/msp_checker.sv
// ----------------------------------------------------------------------------
// msp_checker
// Port-level checks of the partitioned stack memory, bound to the top level.
// ----------------------------------------------------------------------------
module msp_checker
    import msp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [DATA_W-1:0]     m_axis_tdata,
    input logic [STATUS_W-1:0]   m_axis_tuser,
    input logic                  m_axis_tlast,
    input logic                  cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("Output transaction changed while stalled.");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("Error result is not a single zero-data final transaction.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !cfg_ready)
        else $error("Input taken again while a transaction is in work.");

    a_no_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("Result appeared with no transaction in work.");

endmodule

bind multi_stack_partitioned_memory_unit msp_checker u_msp_checker (.*);
